/* rtl/core/skq_pkg.sv */
`timescale 1ns / 1ps
package skq_pkg;

	// data word width
	localparam int VALUE_W = 32;

	// width of the keep count register
	localparam int KEEP_W = 5;

	// reset value of the keep count register
	localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;

	// input queue between front and back, power of two so pointers wrap
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;

	typedef logic signed [VALUE_W-1:0] skq_value_t;

	// one input word as it travels through the queue
	typedef struct packed {
		skq_value_t value;
		logic last;
	} skq_item_t;

	// back end: inserting words, or draining the kept values
	typedef enum logic {
		ST_INSERT,
		ST_READ
	} skq_state_t;

endpackage

/* rtl/core/skq_fifo.sv */
`timescale 1ns / 1ps
module skq_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_push,
	output logic               wr_full,
	input  skq_pkg::skq_item_t wr_item,
	output logic               rd_empty,
	input  logic               rd_pop,
	output skq_pkg::skq_item_t rd_item
);
	import skq_pkg::*;

	skq_item_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0] fill_q;
	logic do_wr;
	logic do_rd;

	assign wr_full = (fill_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign rd_empty = (fill_q == '0);
	assign do_wr = wr_push && !wr_full;
	assign do_rd = rd_pop && !rd_empty;
	assign rd_item = mem_q[rd_ptr_q];

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= QPTR_W'(wr_ptr_q + 1'b1);
			end
			if (do_rd) begin
				rd_ptr_q <= QPTR_W'(rd_ptr_q + 1'b1);
			end
			case ({do_wr, do_rd})
				2'b10: fill_q <= (QPTR_W + 1)'(fill_q + 1'b1);
				2'b01: fill_q <= (QPTR_W + 1)'(fill_q - 1'b1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

/* rtl/core/skq_cells.sv */
`timescale 1ns / 1ps
module skq_cells #(
	parameter int CAPACITY = 16,
	parameter int CW = $clog2(CAPACITY + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  skq_pkg::skq_item_t  item,
	input  logic                item_valid,
	output logic                item_pop,
	input  logic [CW-1:0]       eff_keep,
	output logic                empty,
	input  logic                pop,
	output skq_pkg::skq_value_t kept_value,
	output logic                last_result,
	output logic                reading,
	output logic [CW-1:0]       fill_count
);
	import skq_pkg::*;

	// cells hold kept values ascending, cell 0 the smallest
	skq_value_t cell_q [CAPACITY];
	skq_value_t cell_d [CAPACITY];
	logic [CAPACITY-1:0] below;
	logic [CW-1:0] count_q;
	logic [CW:0] count_inc;
	logic [CW-1:0] count_ins;
	skq_state_t state_q;
	skq_state_t state_d;
	logic out_valid_q;
	skq_value_t out_value_q;
	logic out_last_q;
	logic out_free;
	logic shift_en;
	logic drain_last;

	assign out_free = !out_valid_q || pop;
	assign drain_last = (count_q == CW'(1));

	// each cell compares itself to the new word; occupied cells at or below it stay put
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			below[i] = (i < int'(count_q)) && (cell_q[i] <= item.value);
		end
		cell_d[0] = below[0] ? cell_q[0] : item.value;
		for (int i = 1; i < CAPACITY; i++) begin
			if (below[i]) begin
				cell_d[i] = cell_q[i];
			end else if (below[i-1]) begin
				cell_d[i] = item.value;
			end else begin
				cell_d[i] = cell_q[i-1];
			end
		end
	end

	// fill after insertion, clipped to the keep count
	assign count_inc = {1'b0, count_q} + 1'b1;
	assign count_ins = (count_inc > {1'b0, eff_keep}) ? eff_keep : count_inc[CW-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INSERT: begin
				if (item_valid && item.last) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (out_free && drain_last) begin
					state_d = ST_INSERT;
				end
			end
			default: state_d = ST_INSERT;
		endcase
	end

	// control outputs
	always_comb begin
		item_pop = 1'b0;
		shift_en = 1'b0;
		case (state_q)
			ST_INSERT: item_pop = item_valid;
			ST_READ: shift_en = out_free;
			default: begin
				item_pop = 1'b0;
				shift_en = 1'b0;
			end
		endcase
	end

	// cell chain: insert, or shift down one place per drained word
	always_ff @(posedge clk) begin
		if (item_pop) begin
			for (int i = 0; i < CAPACITY; i++) begin
				cell_q[i] <= cell_d[i];
			end
		end else if (shift_en) begin
			for (int i = 0; i < CAPACITY - 1; i++) begin
				cell_q[i] <= cell_q[i+1];
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (shift_en) begin
			out_value_q <= cell_q[0];
			out_last_q <= drain_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INSERT;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (item_pop) begin
				count_q <= count_ins;
			end else if (shift_en) begin
				count_q <= CW'(count_q - 1'b1);
			end
			if (shift_en) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty = !out_valid_q;
	assign kept_value = out_value_q;
	assign last_result = out_last_q;
	assign reading = (state_q == ST_READ);
	assign fill_count = count_q;

endmodule

/* rtl/core/smallest_k_selector.sv */
`timescale 1ns / 1ps
// A word waits in the input queue and enters the cell chain while the back end inserts;
// the end-of-stream word starts readout through the output word register. Throughput:
// one word per cycle while the back end inserts; readout gives one result per cycle while
// the receiver pops, as many as kept; the queue keeps taking words meanwhile until full.
// Reset: clears queue, fill count, output register; keep count goes to 16.
// Stored values are not cleared; only filled cells are ever read.
module smallest_k_selector #(
	parameter int CAPACITY = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  skq_pkg::skq_value_t       sample_value,
	input  logic                      end_of_stream,
	output logic                      empty,
	input  logic                      pop,
	output skq_pkg::skq_value_t       kept_value,
	output logic                      last_result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [skq_pkg::KEEP_W-1:0] cfg_data
);
	import skq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int KW = ((CW > KEEP_W) ? CW : KEEP_W) + 1;

	logic [KEEP_W-1:0] keep_count_q;
	logic [KW-1:0] keep_ext;
	logic [CW-1:0] eff_keep;
	skq_item_t in_item;
	skq_item_t q_item;
	logic q_empty;
	logic q_pop;
	logic reading;
	logic [CW-1:0] fill_count;

	// keep count register; the sender must write it only with no word in flight, which the block does not enforce
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q <= KEEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			keep_count_q <= cfg_data;
		end
	end

	// zero means one, above capacity means capacity
	assign keep_ext = KW'(keep_count_q);
	always_comb begin
		if (keep_ext == '0) begin
			eff_keep = CW'(1);
		end else if (keep_ext > KW'(CAPACITY)) begin
			eff_keep = CW'(CAPACITY);
		end else begin
			eff_keep = keep_ext[CW-1:0];
		end
	end

	assign in_item.value = sample_value;
	assign in_item.last = end_of_stream;

	skq_fifo u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_push  (push),
		.wr_full  (full),
		.wr_item  (in_item),
		.rd_empty (q_empty),
		.rd_pop   (q_pop),
		.rd_item  (q_item)
	);

	skq_cells #(
		.CAPACITY (CAPACITY),
		.CW       (CW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (q_item),
		.item_valid  (!q_empty),
		.item_pop    (q_pop),
		.eff_keep    (eff_keep),
		.empty       (empty),
		.pop         (pop),
		.kept_value  (kept_value),
		.last_result (last_result),
		.reading     (reading),
		.fill_count  (fill_count)
	);

	// draining never starts or runs with nothing kept
	assert property (@(posedge clk) disable iff (!arst_n)
		reading |-> fill_count != '0)
		else $error("readout with empty store");

	// fill never exceeds the number of cells
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_count <= CW'(CAPACITY))
		else $error("fill count beyond capacity");

	// no word leaves the queue while the back end drains
	assert property (@(posedge clk) disable iff (!arst_n)
		reading |-> !q_pop)
		else $error("queue popped during readout");

	// a waiting result word holds steady until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(kept_value) && $stable(last_result)))
		else $error("result word changed while waiting");

endmodule

/* sim/tb_smallest_k_selector.sv */
`timescale 1ns / 1ps
module tb_smallest_k_selector;
	import skq_pkg::*;

	localparam int CAPACITY = 16;
	// idle cycles before a keep count write: input queue, insert, full readout
	localparam int DRAIN_CYCLES = 32;
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEM_TARGET = 460;

	localparam skq_value_t VAL_MAX = 32'sh7FFF_FFFF;
	localparam skq_value_t VAL_MIN = 32'sh8000_0000;

	// one expected readout word
	typedef struct packed {
		skq_value_t value;
		logic last;
	} kept_word_t;

	// tracks the kept values and the readout words they produce
	class kept_value_board;
		skq_value_t store[CAPACITY];
		int unsigned fill;
		logic [KEEP_W-1:0] keep_reg;
		kept_word_t readout_q[$];
		int errors;

		function new();
			fill = 0;
			keep_reg = KEEP_RESET;
			errors = 0;
		endfunction

		function void set_keep(logic [KEEP_W-1:0] k);
			keep_reg = k;
		endfunction

		// zero behaves as one, anything past the store size as the store size
		function int unsigned active_keep();
			int unsigned k;
			k = keep_reg;
			if (k == 0)
				k = 1;
			if (k > CAPACITY)
				k = CAPACITY;
			return k;
		endfunction

		// insert an accepted word, trim to keep count, queue readout on end of stream
		function void take_sample(skq_value_t v, logic eos);
			skq_value_t work[CAPACITY+1];
			kept_word_t w;
			int n;
			int i;
			int drop;
			int k;
			n = fill;
			k = active_keep();
			for (i = 0; i < n; i++)
				work[i] = store[i];
			// descending order: new value goes after all entries >= it
			i = n;
			while (i > 0 && work[i-1] < v) begin
				work[i] = work[i-1];
				i--;
			end
			work[i] = v;
			n++;
			drop = (n > k) ? n - k : 0;
			n -= drop;
			for (i = 0; i < n; i++)
				store[i] = work[drop + i];
			fill = n;
			if (eos) begin
				for (i = 0; i < n; i++) begin
					w.value = store[n - 1 - i];
					w.last = (i == n - 1);
					readout_q = {readout_q, w};
				end
				fill = 0;
			end
		endfunction

		function void match_result(skq_value_t v, logic last);
			kept_word_t w;
			if (readout_q.size() == 0) begin
				$display("%0t: unexpected result word: actual value %0d last %0b",
					$time, v, last);
				errors++;
				return;
			end
			w = readout_q.pop_front();
			if (v !== w.value) begin
				$display("%0t: kept_value mismatch: expected %0d, actual %0d",
					$time, w.value, v);
				errors++;
			end
			if (last !== w.last) begin
				$display("%0t: last_result mismatch: expected %0b, actual %0b",
					$time, w.last, last);
				errors++;
			end
		endfunction

		function int pending();
			return readout_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	skq_value_t sample_value;
	logic end_of_stream;
	logic empty;
	logic pop;
	skq_value_t kept_value;
	logic last_result;
	logic cfg_valid;
	logic cfg_ready;
	logic [KEEP_W-1:0] cfg_data;

	kept_value_board board = new();
	int unsigned cycle_count = 0;
	int items_sent = 0;
	int burst_left = 0;

	smallest_k_selector #(
		.CAPACITY(CAPACITY)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.sample_value(sample_value),
		.end_of_stream(end_of_stream),
		.empty(empty),
		.pop(pop),
		.kept_value(kept_value),
		.last_result(last_result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// push one word and hold it until accepted
	task automatic send_word(input skq_value_t v, input logic eos);
		push <= 1'b1;
		sample_value <= v;
		end_of_stream <= eos;
		do
			@(posedge clk);
		while (full);
		board.take_sample(v, eos);
		items_sent++;
	endtask

	// sender bursts: random burst length, random gap in front of each burst
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	// all readout words in, then let the input queue and back end settle
	task automatic wait_idle();
		push <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_keep(input logic [KEEP_W-1:0] k);
		cfg_valid <= 1'b1;
		cfg_data <= k;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.set_keep(k);
	endtask

	function automatic logic [KEEP_W-1:0] pick_keep();
		case ($urandom_range(0, 7))
			0: return 5'd1;
			1: return 5'd16;
			2: return 5'd0;
			3: return 5'($urandom_range(17, 31));
			default: return 5'($urandom_range(2, 15));
		endcase
	endfunction

	// mix of extremes, a narrow band for duplicates, and full-range values
	function automatic skq_value_t pick_value();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: return VAL_MAX;
					1: return VAL_MIN;
					2: return 32'sd0;
					3: return -32'sd1;
					default: return 32'sd1;
				endcase
			end
			1, 2, 3: return skq_value_t'(int'($urandom_range(0, 16)) - 8);
			default: return skq_value_t'($urandom);
		endcase
	endfunction

	// receiver: stall pattern with a randomly reselected mode
	initial begin
		int rx_mode;
		int rx_cnt;
		rx_mode = 0;
		rx_cnt = 0;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				board.match_result(kept_value, last_result);
			rx_cnt++;
			if (rx_cnt % 64 == 0)
				rx_mode = $urandom_range(0, 3);
			case (rx_mode)
				0: pop <= 1'b1;
				1: pop <= 1'($urandom_range(0, 1));
				2: pop <= (rx_cnt % 5 == 0);
				default: pop <= ($urandom_range(0, 9) == 0);
			endcase
		end
	end

	initial begin
		int len;
		int j;
		logic eos;
		arst_n = 1'b0;
		push = 1'b0;
		sample_value = '0;
		end_of_stream = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// extremes, duplicates, full store size
		write_keep(5'd16);
		send_word(VAL_MAX, 1'b0);
		send_word(VAL_MIN, 1'b0);
		send_word(32'sd0, 1'b0);
		send_word(-32'sd1, 1'b0);
		send_word(32'sd1, 1'b0);
		send_word(32'sd5, 1'b0);
		send_word(32'sd5, 1'b0);
		send_word(32'sd5, 1'b0);
		send_word(-32'sd7, 1'b1);

		// keep count zero acts as one
		wait_idle();
		write_keep(5'd0);
		send_word(32'sd10, 1'b0);
		send_word(-32'sd3, 1'b0);
		send_word(32'sd7, 1'b0);
		send_word(32'sd2, 1'b1);

		// keep count above store size
		wait_idle();
		write_keep(5'd31);
		send_word(VAL_MIN, 1'b0);
		send_word(VAL_MAX, 1'b0);
		send_word(32'sd0, 1'b1);

		// keep count lowered in the middle of a stream
		wait_idle();
		write_keep(5'd16);
		send_word(32'sd40, 1'b0);
		send_word(-32'sd12, 1'b0);
		send_word(32'sd3, 1'b0);
		send_word(VAL_MAX, 1'b0);
		send_word(-32'sd12, 1'b0);
		send_word(32'sd99, 1'b0);
		wait_idle();
		write_keep(5'd2);
		send_word(32'sd1, 1'b1);

		// random streams with random keep counts
		while (items_sent < ITEM_TARGET) begin
			wait_idle();
			write_keep(pick_keep());
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
			for (j = 0; j < len; j++) begin
				eos = (j == len - 1);
				if (!eos && $urandom_range(0, 39) == 0) begin
					wait_idle();
					write_keep(pick_keep());
				end
				pace();
				send_word(pick_value(), eos);
			end
		end

		wait_idle();
		if (board.errors == 0 && board.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* smallest_k_selector.f */
rtl/core/skq_pkg.sv
rtl/core/skq_fifo.sv
rtl/core/skq_cells.sv
rtl/core/smallest_k_selector.sv
sim/tb_smallest_k_selector.sv
